/* rtl/tsptt_pkg.sv */
`default_nettype none

package tsptt_pkg;

    localparam int KEY_W   = 64;
    localparam int BOUND_W = 24;
    localparam int KIND_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORE  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOME,
        ST_RD_NEXT,
        ST_DECIDE,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [BOUND_W-1:0] bound;
    } t_entry;

    localparam int ENTRY_W = KEY_W + BOUND_W;

endpackage

`default_nettype wire

/* rtl/tsptt_ram.sv */
`default_nettype none

module tsptt_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/tsptt_home.sv */
`default_nettype none

module tsptt_home
    import tsptt_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [KEY_W-1:0]         i_key,
    output logic                          o_done,
    output logic      [$clog2(DEPTH)-1:0] o_home
);

    localparam int AW      = $clog2(DEPTH);
    localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);
    localparam int NBYTES  = KEY_W / 8;
    localparam int BCW     = $clog2(NBYTES);

    generate
        if (IS_POW2) begin : g_mask
            logic          r_done;
            logic [AW-1:0] r_home;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_home <= i_key[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_reduce
            logic             r_busy;
            logic             r_done;
            logic [BCW-1:0]   r_byte;
            logic [KEY_W-1:0] r_key;
            logic [AW-1:0]    r_rem;
            logic [AW-1:0]    n_rem;

            // eight shift and conditional subtract steps, one byte a cycle, msb first
            always_comb begin
                logic [AW:0] rem;
                rem = {1'b0, r_rem};
                for (int i = 0; i < 8; i++) begin
                    rem = {rem[AW-1:0], r_key[KEY_W-1-i]};
                    if (rem >= (AW+1)'(DEPTH)) begin
                        rem = rem - (AW+1)'(DEPTH);
                    end
                end
                n_rem = rem[AW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_byte <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_byte <= '0;
                    end else if (r_busy) begin
                        r_byte <= r_byte + BCW'(1);
                        if (r_byte == BCW'(NBYTES - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_key <= {r_key[KEY_W-9:0], 8'h00};
                    r_rem <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_home = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

/* rtl/two_slot_probe_transposition_table_core.sv */
// store or lookup: one item at a time, no new input until it is done; home slot from
// the key's low bits when TABLE_DEPTH is a power of two, else by a byte-serial modulo
// reducer; both probes share one ram read port; a lookup result is registered in the
// decide step, held there while the output stalls; clear: one entry written a cycle,
// no input taken meanwhile; reset: synchronous, active low; then a clearing pass over
// all TABLE_DEPTH slots before the first input transaction is taken
`default_nettype none

module two_slot_probe_transposition_table_core
    import tsptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [KIND_W-1:0]  i_in_kind,
    input  wire logic [KEY_W-1:0]   i_in_key,
    input  wire logic [BOUND_W-1:0] i_in_bound_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_out_hit,
    output logic      [BOUND_W-1:0] o_out_bound_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    t_state r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_home;
    logic [KEY_W-1:0]   r_key;
    logic [BOUND_W-1:0] r_bound;
    logic               r_lookup;
    t_entry             r_hent;
    logic               r_out_valid, n_out_valid;
    logic               r_out_hit;
    logic [BOUND_W-1:0] r_out_bound;

    logic               accept;
    logic               home_done;
    logic [AW-1:0]      home_val;
    logic               has_next;
    logic [AW-1:0]      next_addr;
    logic               home_match, next_match, next_free;
    logic               out_free;
    logic               load_out;
    logic               hit;
    logic [BOUND_W-1:0] hit_bound;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic [AW-1:0]      ram_raddr;
    t_entry             ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_bits;

    tsptt_home #(.DEPTH(TABLE_DEPTH)) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_in_key),
        .o_done  (home_done),
        .o_home  (home_val)
    );

    tsptt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    assign ram_rdata  = t_entry'(ram_rdata_bits);
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign has_next   = (r_home != LAST);
    assign next_addr  = has_next ? (r_home + AW'(1)) : r_home;
    assign home_match = (r_hent.key == r_key);
    assign next_match = has_next && (ram_rdata.key == r_key);
    assign next_free  = has_next && (ram_rdata.key == '0);
    assign hit        = home_match || next_match;
    assign hit_bound  = home_match ? r_hent.bound :
                        (next_match ? ram_rdata.bound : '0);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        ram_we      = 1'b0;
        ram_waddr   = r_home;
        ram_wdata   = '{key: r_key, bound: r_bound};
        ram_raddr   = next_addr;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_in_kind))
                        KIND_STORE, KIND_LOOKUP: n_state = ST_HOME;
                        KIND_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_cnt   = '0;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_HOME: begin
                ram_raddr = home_val;
                if (home_done) begin
                    n_state = ST_RD_NEXT;
                end
            end
            ST_RD_NEXT: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_lookup) begin
                    if (out_free) begin
                        load_out    = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    ram_we  = 1'b1;
                    n_state = ST_IDLE;
                    if (!home_match && (next_match || next_free)) begin
                        ram_waddr = next_addr;
                    end
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = '0;
                n_cnt     = r_cnt + AW'(1);
                if (r_cnt == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key    <= i_in_key;
            r_bound  <= i_in_bound_in;
            r_lookup <= (t_kind'(i_in_kind) == KIND_LOOKUP);
        end
        if (r_state == ST_HOME && home_done) begin
            r_home <= home_val;
        end
        if (r_state == ST_RD_NEXT) begin
            r_hent <= ram_rdata;
        end
        if (load_out) begin
            r_out_hit   <= hit;
            r_out_bound <= hit_bound;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_hit       = r_out_hit;
    assign o_out_bound_out = r_out_bound;

    a_out_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DECIDE))
        else $error("result raised outside the decide step");

    a_home_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOME && home_done) |-> (home_val <= LAST))
        else $error("home slot beyond table depth");

    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_cnt == LAST) |=> (r_state == ST_IDLE))
        else $error("clearing pass did not end at the last slot");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_HOME || r_state == ST_RD_NEXT) |-> !ram_we)
        else $error("table written outside a store or clear");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_bound)))
        else $error("pending result lost while stalled");

endmodule

`default_nettype wire

/* tb/two_slot_probe_transposition_table_core_checker.sv */
`default_nettype none

module two_slot_probe_transposition_table_core_checker
    import tsptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [KIND_W-1:0]  i_in_kind,
    input  wire logic [KEY_W-1:0]   i_in_key,
    input  wire logic [BOUND_W-1:0] i_in_bound_in,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_out_hit,
    input  wire logic [BOUND_W-1:0] i_out_bound_out,
    output int                      o_mismatches,
    output int                      o_awaiting
);

    localparam logic [KEY_W-1:0] DEPTH_K = KEY_W'(TABLE_DEPTH);

    typedef struct packed {
        logic               hit;
        logic [BOUND_W-1:0] bound;
    } t_answer;

    logic [KEY_W-1:0]   shadow_keys   [TABLE_DEPTH];
    logic [BOUND_W-1:0] shadow_bounds [TABLE_DEPTH];
    t_answer            lookup_answers[$];
    int                 mismatches;

    function automatic int home_of(input logic [KEY_W-1:0] key);
        return int'(key % DEPTH_K);
    endfunction

    task automatic wipe_shadow();
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            shadow_keys[s]   = '0;
            shadow_bounds[s] = '0;
        end
    endtask

    task automatic store_entry(input logic [KEY_W-1:0] key, input logic [BOUND_W-1:0] bound);
        int home;
        home = home_of(key);
        if (shadow_keys[home] == key) begin
            shadow_bounds[home] = bound;
        end else if (home < TABLE_DEPTH - 1 &&
                     (shadow_keys[home+1] == key || shadow_keys[home+1] == '0)) begin
            shadow_keys[home+1]   = key;
            shadow_bounds[home+1] = bound;
        end else begin
            shadow_keys[home]   = key;
            shadow_bounds[home] = bound;
        end
    endtask

    function automatic t_answer probe_entry(input logic [KEY_W-1:0] key);
        int      home;
        t_answer ans;
        home = home_of(key);
        ans  = '0;
        if (shadow_keys[home] == key) begin
            ans.hit   = 1'b1;
            ans.bound = shadow_bounds[home];
        end else if (home < TABLE_DEPTH - 1 && shadow_keys[home+1] == key) begin
            ans.hit   = 1'b1;
            ans.bound = shadow_bounds[home+1];
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            wipe_shadow();
            lookup_answers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (lookup_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected lookup answer hit=%0b bound=%06h", $time,
                             i_out_hit, i_out_bound_out);
                end else begin
                    want = lookup_answers.pop_front();
                    if (i_out_hit !== want.hit) begin
                        mismatches++;
                        $display("%0t: hit mismatch: expected %0b, got %0b", $time,
                                 want.hit, i_out_hit);
                    end
                    if (i_out_bound_out !== want.bound) begin
                        mismatches++;
                        $display("%0t: bound mismatch: expected %06h, got %06h", $time,
                                 want.bound, i_out_bound_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_kind)
                    KIND_STORE: store_entry(i_in_key, i_in_bound_in);
                    KIND_LOOKUP: lookup_answers.push_back(probe_entry(i_in_key));
                    KIND_CLEAR: wipe_shadow();
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_awaiting   <= lookup_answers.size();
    end

endmodule

`default_nettype wire

/* tb/two_slot_probe_transposition_table_core_tb.sv */
`default_nettype none

module two_slot_probe_transposition_table_core_tb;
    import tsptt_pkg::*;

    localparam int TABLE_DEPTH  = 4096;
    localparam int HOME_W       = $clog2(TABLE_DEPTH);
    localparam int TAG_W        = KEY_W - HOME_W;
    localparam int RANDOM_ITEMS = 1880;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE       = 30;
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [BOUND_W-1:0] BOUND_MAX   = '1;

    logic               i_clk;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic [KIND_W-1:0]  i_in_kind       = KIND_STORE;
    logic [KEY_W-1:0]   i_in_key        = '0;
    logic [BOUND_W-1:0] i_in_bound_in   = '0;
    logic               i_out_stall     = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_out_hit;
    logic [BOUND_W-1:0] o_out_bound_out;

    int mismatches;
    int awaiting;
    int idle_cycles = 0;
    int answers     = 0;
    int hits        = 0;
    int n_store     = 0;
    int n_lookup    = 0;
    int n_clear     = 0;
    int n_unused    = 0;
    bit calm        = 1'b0;

    logic [TAG_W-1:0] tag_pool    [8];
    logic [KEY_W-1:0] recent_keys [$];

    two_slot_probe_transposition_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_kind      (i_in_kind),
        .i_in_key       (i_in_key),
        .i_in_bound_in  (i_in_bound_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_hit      (o_out_hit),
        .o_out_bound_out(o_out_bound_out)
    );

    two_slot_probe_transposition_table_core_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) table_watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_kind      (i_in_kind),
        .i_in_key       (i_in_key),
        .i_in_bound_in  (i_in_bound_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_hit      (o_out_hit),
        .i_out_bound_out(o_out_bound_out),
        .o_mismatches   (mismatches),
        .o_awaiting     (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BOUND_W-1:0] pick_bound();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return BOUND_MAX;
        end
        return BOUND_W'($urandom);
    endfunction

    // keys crowd a few neighbouring homes so probes collide and overwrite
    function automatic logic [KEY_W-1:0] pick_key();
        logic [HOME_W-1:0] home;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return {$urandom, $urandom};
        end else if (r < 55 && recent_keys.size() > 0) begin
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end
        case ($urandom_range(0, 3))
            0: home = HOME_W'($urandom_range(0, 7));
            1: home = HOME_W'(TABLE_DEPTH - 1 - $urandom_range(0, 2));
            2: home = HOME_W'(2000 + $urandom_range(0, 5));
            default: home = HOME_W'($urandom_range(0, TABLE_DEPTH - 1));
        endcase
        return {tag_pool[$urandom_range(0, 7)], home};
    endfunction

    task automatic issue(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [BOUND_W-1:0] bound);
        int gap;
        i_in_valid    <= 1'b1;
        i_in_kind     <= kind;
        i_in_key      <= key;
        i_in_bound_in <= bound;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (kind)
            KIND_STORE: n_store++;
            KIND_LOOKUP: n_lookup++;
            KIND_CLEAR: n_clear++;
            default: n_unused++;
        endcase
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaiting != 0);
    endtask

    initial begin : out_pacing
        int n;
        forever begin
            @(posedge i_clk);
            n = pick_gap();
            if (n == 0) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            answers <= answers + 1;
            if (o_out_hit) begin
                hits <= hits + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        logic [KEY_W-1:0] kc;
        logic [KEY_W-1:0] kl;
        logic [KEY_W-1:0] key;
        int               r;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int t = 2; t < 8; t++) begin
            tag_pool[t] = TAG_W'({$urandom, $urandom});
        end
        ka = {TAG_W'(1), HOME_W'(10)};
        kb = {TAG_W'(2), HOME_W'(10)};
        kc = {TAG_W'(3), HOME_W'(10)};
        kl = {TAG_W'(5), HOME_W'(TABLE_DEPTH - 1)};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key zero against empty slots, last slot as home, second probe, eviction
        issue(KIND_LOOKUP, '0, pick_bound());
        issue(KIND_STORE, '0, BOUND_MAX);
        issue(KIND_LOOKUP, '0, '0);
        issue(KIND_STORE, '1, BOUND_W'(1));
        issue(KIND_STORE, kl, BOUND_W'(24'h123456));
        issue(KIND_LOOKUP, '1, '0);
        issue(KIND_LOOKUP, kl, '0);
        issue(KIND_STORE, ka, BOUND_W'(24'hAAAAAA));
        issue(KIND_STORE, kb, BOUND_W'(24'h555555));
        issue(KIND_STORE, kc, BOUND_W'(2));
        issue(KIND_LOOKUP, ka, '0);
        issue(KIND_LOOKUP, kb, '0);
        issue(KIND_LOOKUP, kc, '0);
        issue(KIND_STORE, kb, BOUND_MAX);
        issue(KIND_LOOKUP, kb, '0);
        issue(KIND_STORE, kc, BOUND_W'(3));
        issue(KIND_LOOKUP, kc, BOUND_MAX);
        issue(KIND_UNUSED, '1, BOUND_MAX);
        issue(KIND_LOOKUP, {32'hAAAAAAAA, 32'hAAAAAAAA}, '0);
        issue(KIND_STORE, {32'h55555555, 32'h55555555}, '0);
        issue(KIND_LOOKUP, {32'h55555555, 32'h55555555}, '0);
        issue(KIND_CLEAR, '1, BOUND_MAX);
        issue(KIND_LOOKUP, kb, '0);
        issue(KIND_LOOKUP, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n % 400) >= 340;
            if (n == RANDOM_ITEMS / 2) begin
                drain();
            end
            r   = $urandom_range(0, 999);
            key = pick_key();
            if (r < 8) begin
                issue(KIND_CLEAR, key, pick_bound());
                recent_keys.delete();
            end else if (r < 40) begin
                issue(KIND_UNUSED, key, pick_bound());
            end else if (r < 500) begin
                issue(KIND_STORE, key, pick_bound());
                recent_keys.push_back(key);
                if (recent_keys.size() > 16) begin
                    void'(recent_keys.pop_front());
                end
            end else begin
                issue(KIND_LOOKUP, key, pick_bound());
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d stores, %0d lookups, %0d clears, %0d unused-kind items",
                 n_store, n_lookup, n_clear, n_unused);
        $display("received %0d lookup answers, %0d of them hits", answers, hits);
        if (mismatches == 0 && awaiting == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/tsptt_pkg.sv
rtl/tsptt_ram.sv
rtl/tsptt_home.sv
rtl/two_slot_probe_transposition_table_core.sv
tb/two_slot_probe_transposition_table_core_checker.sv
tb/two_slot_probe_transposition_table_core_tb.sv
